@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WRMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define WRMC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/core/wrmc_pkg.sv @@
// constants, types and the cordic angle table of the waypoint controller
// no dependencies
`timescale 1ns / 1ps
package wrmc_pkg;

  localparam int PROFILE_ENTRIES = 256;
  localparam int CORDIC_STEPS    = 16;
  localparam int SHORT_MOVE_MM   = 50;

  localparam int CORDIC_N  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CW        = 40;
  localparam int PROF_LOG2 = $clog2(PROFILE_ENTRIES);
  localparam int K_W       = PROF_LOG2 + 1;
  localparam int KS_W      = 17 + PROF_LOG2 + 1;

  localparam int DD_W = 34;
  localparam int DV_W = 17;

  localparam logic [29:0] KINV         = 30'd652032874;
  localparam logic [26:0] ROT_END_LIM  = 27'd65470464;
  localparam logic [26:0] MOVE_END_LIM = 27'd6225920;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] SPEED_OFFSET = 17'd48;

  localparam logic [1:0] PH_STANDBY = 2'd0;
  localparam logic [1:0] PH_ROTATE  = 2'd1;
  localparam logic [1:0] PH_MOVE    = 2'd2;

  localparam logic [1:0] DM_NONE    = 2'd0;
  localparam logic [1:0] DM_LEFT    = 2'd1;
  localparam logic [1:0] DM_RIGHT   = 2'd2;
  localparam logic [1:0] DM_FORWARD = 2'd3;

  localparam logic [1:0] CFG_WAYPOINT_COUNT = 2'd0;
  localparam logic [1:0] CFG_ROTATE_MAX     = 2'd1;
  localparam logic [1:0] CFG_MOVE_MAX       = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [15:0] cordic_atan(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd8192;
      5'd1:  v = 16'd4836;
      5'd2:  v = 16'd2555;
      5'd3:  v = 16'd1297;
      5'd4:  v = 16'd651;
      5'd5:  v = 16'd326;
      5'd6:  v = 16'd163;
      5'd7:  v = 16'd81;
      5'd8:  v = 16'd41;
      5'd9:  v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/wrmc_cordic.sv @@
// iterative vectoring cordic, one micro-rotation per cycle
// depends on wrmc_pkg
`timescale 1ns / 1ps
module wrmc_cordic import wrmc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output unit_stat_t           stat,
  output logic signed [CW-1:0] mag,
  output logic [15:0]          angle
);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic [15:0]          z;
  logic [4:0]           step;
  logic                 busy;
  logic                 done;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign xs = x >>> step;
  assign ys = y >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // left half plane: rotate by half a turn first
        if (x_in < 0) begin
          x <= -x_in;
          y <= -y_in;
          z <= 16'h8000;
        end else begin
          x <= x_in;
          y <= y_in;
          z <= 16'h0000;
        end
        step <= 5'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + cordic_atan(step);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - cordic_atan(step);
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign mag       = x;
  assign angle     = z;

endmodule

@@ rtl/core/wrmc_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on wrmc_pkg
`timescale 1ns / 1ps
module wrmc_div import wrmc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DD_W-1:0] dividend,
  input  logic [DV_W-1:0] divisor,
  output unit_stat_t      stat,
  output logic [DD_W-1:0] quotient
);

  logic [DV_W-1:0] rem;
  logic [DV_W-1:0] dvs;
  logic [DD_W-1:0] quo;
  logic [5:0]      cnt;
  logic            busy;
  logic            done;
  logic [DV_W:0]   trial;

  assign trial = {rem, quo[DD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        dvs  <= divisor;
        quo  <= dividend;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= DV_W'(trial - {1'b0, dvs});
          quo <= {quo[DD_W-2:0], 1'b1};
        end else begin
          rem <= trial[DV_W-1:0];
          quo <= {quo[DD_W-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

@@ rtl/core/waypoint_rotate_move_controller.sv @@
// top level of the waypoint controller: sequencer, phase state, output register
// depends on wrmc_pkg, wrmc_cordic, wrmc_div and assert_macros.svh
`timescale 1ns / 1ps
//
// channel   handshake              payload
// -------   --------------------   ------------------------------------------
// in        in_valid / in_stall    target_x/y, target_backward, pose_x/y,
//                                  pose_heading, obstacle_front/back, run_enable
// out       out_valid / out_stall  drive_enable, drive_mode, left/right_speed,
//                                  phase_now, waypoint_now, waypoint_reached
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// an item reaches the output register after one pass of the shared cordic in
// standby, and in rotate or move after up to three passes of the shared cordic,
// up to two passes of the shared divider and the sequencer steps between them
// the block takes one item at a time; in_stall is high from acceptance until
// the result is loaded into the output register
// a finished result waits in the output register while out_stall is high; the
// next item can be accepted meanwhile, and its result waits for the register
// rst is synchronous; it clears phase, waypoint index, captured turn and
// distance, configuration and the handshake state
`include "assert_macros.svh"
module waypoint_rotate_move_controller import wrmc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] target_x,
  input  logic signed [15:0] target_y,
  input  logic               target_backward,
  input  logic signed [15:0] pose_x,
  input  logic signed [15:0] pose_y,
  input  logic [15:0]        pose_heading,
  input  logic               obstacle_front,
  input  logic               obstacle_back,
  input  logic               run_enable,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic               drive_enable,
  output logic [1:0]         drive_mode,
  output logic [16:0]        left_speed,
  output logic [16:0]        right_speed,
  output logic [1:0]         phase_now,
  output logic [7:0]         waypoint_now,
  output logic               waypoint_reached,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_VEC_GO, S_VEC_WAIT, S_MUL_LO, S_MUL_HI, S_DIST, S_PHASE,
    S_DIV_GO, S_DIV_WAIT, S_TEST, S_PROF_X, S_PROF_T, S_NUM_GO, S_NUM_WAIT,
    S_DEN_GO, S_DEN_WAIT, S_PDIV, S_PDIV_GO, S_PDIV_WAIT, S_SPEED, S_STEER,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [7:0] waypoint_count;
  logic [9:0] rotate_speed_max;
  logic [9:0] move_speed_max;

  // controller state kept across items
  logic [1:0]  phase;
  logic [7:0]  waypoint_index;
  logic [15:0] initial_turn;
  logic [16:0] initial_distance;

  // latched item fields
  logic        backward;
  logic        ob_front;
  logic        ob_back;
  logic        run;
  logic [15:0] heading;

  // working registers
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [15:0]          bearing;
  logic [38:0]          magu;
  logic [69:0]          acc;
  logic [16:0]          dist_mm;
  logic signed [15:0]   err;
  logic [DD_W-1:0]      dd;
  logic [DV_W-1:0]      dv;
  logic                 neg;
  logic [16:0]          p;
  logic [16:0]          kx;
  logic [33:0]          t1;
  logic [15:0]          num;
  logic [15:0]          den;
  logic [16:0]          prof;
  logic [9:0]           peak;
  logic [4:0]           prof_a;
  logic [16:0]          sp;

  // pending result
  logic        r_en;
  logic [1:0]  r_mode;
  logic [16:0] r_lsp;
  logic [16:0] r_rsp;
  logic        r_reached;

  // shared units
  unit_stat_t           cstat;
  unit_stat_t           dstat;
  logic signed [CW-1:0] c_mag;
  logic [15:0]          c_angle;
  logic [DD_W-1:0]      quot;
  logic                 c_start;
  logic                 d_start;

  // combinational helpers
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic [49:0]        prod_lo;
  logic [48:0]        prod_hi;
  logic [15:0]        turn_init;
  logic [16:0]        turn_abs;
  logic [16:0]        err_abs;
  logic [16:0]        dist_init;
  logic [16:0]        p_calc;
  logic [26:0]        p_1000;
  logic [26:0]        p_100;
  logic [KS_W-1:0]    ksum;
  logic [K_W-1:0]     k;
  logic [16:0]        x_of_p;
  logic [7:0]         idx_next;
  logic               blocked;
  logic [16:0]        sp_eff;
  logic [16:0]        fac;
  logic [33:0]        steer_prod;
  logic [16:0]        scaled;
  logic [26:0]        peak_prod;
  logic [14:0]        num_pos;
  logic               out_load;

  assign dx = 17'(target_x) - 17'(pose_x);
  assign dy = 17'(target_y) - 17'(pose_y);

  // distance scaling by the cordic gain, split into two partial products
  assign prod_lo = 50'(magu[19:0]) * 50'(KINV);
  assign prod_hi = 49'(magu[38:20]) * 49'(KINV);

  // capture on first tick of a phase
  assign turn_init = (initial_turn == 16'd0) ? err : initial_turn;
  assign turn_abs  = turn_init[15] ? (17'd0 - {1'b1, turn_init}) : {1'b0, turn_init};
  assign err_abs   = err[15] ? (17'd0 - {1'b1, err}) : {1'b0, err};
  assign dist_init = (initial_distance == 17'd0) ? dist_mm : initial_distance;

  // progression from the quotient, clamped to [0, 1]
  always_comb begin
    if (phase == PH_ROTATE && neg) begin
      p_calc = ONE_Q16;
    end else if (quot[DD_W-1:16] != '0) begin
      p_calc = 17'd0;
    end else begin
      p_calc = ONE_Q16 - {1'b0, quot[15:0]};
    end
  end

  assign p_1000 = 27'(p) * 27'(1000);
  assign p_100  = 27'(p) * 27'(100);

  // profile index and its abscissa
  assign ksum   = KS_W'({p, {PROF_LOG2{1'b0}}}) + KS_W'(32768);
  assign k      = ksum[16 +: K_W];
  assign x_of_p = 17'(k) << (16 - PROF_LOG2);

  assign idx_next = (waypoint_index < 8'd255) ? (waypoint_index + 8'd1) : waypoint_index;
  assign blocked  = (ob_front && !backward) || (ob_back && backward);

  assign num_pos   = num[15] ? 15'd0 : num[14:0];
  assign peak_prod = 27'(peak) * 27'(prof);

  // differential steering from heading error
  assign sp_eff     = (phase == PH_MOVE && blocked) ? 17'd0 : sp;
  assign fac        = 17'(32'sd32768 - 32'(err));
  assign steer_prod = 34'(sp_eff) * 34'(fac);
  assign scaled     = steer_prod[31:15];

  assign c_start  = (state == S_VEC_GO) || (state == S_NUM_GO) || (state == S_DEN_GO);
  assign d_start  = (state == S_DIV_GO) || (state == S_PDIV_GO);
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // result moves into the output register when it is empty or being taken
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  wrmc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (c_start),
    .x_in  (cx),
    .y_in  (cy),
    .stat  (cstat),
    .mag   (c_mag),
    .angle (c_angle)
  );

  wrmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (d_start),
    .dividend (dd),
    .divisor  (dv),
    .stat     (dstat),
    .quotient (quot)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count   <= 8'd0;
      rotate_speed_max <= 10'd0;
      move_speed_max   <= 10'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAYPOINT_COUNT: waypoint_count   <= cfg_data[7:0];
        CFG_ROTATE_MAX:     rotate_speed_max <= cfg_data[9:0];
        CFG_MOVE_MAX:       move_speed_max   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      phase            <= PH_STANDBY;
      waypoint_index   <= 8'd0;
      initial_turn     <= 16'd0;
      initial_distance <= 17'd0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // differences scaled by 256 for the cordic
            cx       <= {{(CW-25){dx[16]}}, dx, 8'd0};
            cy       <= {{(CW-25){dy[16]}}, dy, 8'd0};
            backward <= target_backward;
            ob_front <= obstacle_front;
            ob_back  <= obstacle_back;
            run      <= run_enable;
            heading  <= pose_heading;
            state    <= S_VEC_GO;
          end
        end
        S_VEC_GO: state <= S_VEC_WAIT;
        S_VEC_WAIT: begin
          if (cstat.done) begin
            bearing <= c_angle;
            magu    <= c_mag[CW-1] ? 39'd0 : c_mag[38:0];
            state   <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          acc   <= 70'(prod_lo) + (70'd1 << 37);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          acc   <= acc + (70'(prod_hi) << 20);
          state <= S_DIST;
        end
        S_DIST: begin
          dist_mm <= (acc[69:55] != '0) ? 17'd131071 : acc[54:38];
          err     <= bearing - heading;
          state   <= S_PHASE;
        end
        S_PHASE: begin
          r_en      <= 1'b0;
          r_lsp     <= 17'd0;
          r_rsp     <= 17'd0;
          r_reached <= 1'b0;
          unique case (phase)
            PH_STANDBY: begin
              r_mode <= DM_NONE;
              if (waypoint_index < waypoint_count && run) begin
                phase <= PH_ROTATE;
              end
              state <= S_FINISH;
            end
            PH_ROTATE: begin
              initial_turn <= turn_init;
              r_mode       <= (err > 0) ? DM_LEFT : DM_RIGHT;
              peak         <= rotate_speed_max;
              prof_a       <= 5'd20;
              if (turn_init == 16'd0) begin
                p     <= ONE_Q16;
                state <= S_TEST;
              end else begin
                dd    <= {1'b0, err_abs, 16'd0};
                dv    <= turn_abs;
                neg   <= err[15] ^ turn_init[15];
                state <= S_DIV_GO;
              end
            end
            PH_MOVE: begin
              initial_distance <= dist_init;
              r_mode           <= DM_FORWARD;
              // short moves run a gentler, slower profile
              if (dist_init < 17'(SHORT_MOVE_MM)) begin
                peak   <= 10'd10;
                prof_a <= 5'd10;
              end else begin
                peak   <= move_speed_max;
                prof_a <= 5'd20;
              end
              neg <= 1'b0;
              if (dist_init == 17'd0) begin
                p     <= ONE_Q16;
                state <= S_TEST;
              end else begin
                dd    <= {1'b0, dist_mm, 16'd0};
                dv    <= dist_init;
                state <= S_DIV_GO;
              end
            end
            default: begin
              // unused phase code falls back to standby
              r_mode <= DM_NONE;
              phase  <= PH_STANDBY;
              state  <= S_FINISH;
            end
          endcase
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (dstat.done) begin
            p     <= p_calc;
            state <= S_TEST;
          end
        end
        S_TEST: begin
          kx <= x_of_p;
          if (phase == PH_ROTATE) begin
            if (p_1000 > ROT_END_LIM) begin
              // rotation done: drive off, mode keeps the sense
              phase        <= PH_MOVE;
              initial_turn <= 16'd0;
              state        <= S_FINISH;
            end else begin
              state <= S_PROF_X;
            end
          end else begin
            // an obstacle or the end of the move drops the captured distance
            if (blocked || (p_100 > MOVE_END_LIM)) begin
              initial_distance <= 17'd0;
            end
            if (p_100 > MOVE_END_LIM) begin
              // move done: advance the route
              waypoint_index   <= idx_next;
              phase            <= (idx_next >= waypoint_count) ? PH_STANDBY : PH_ROTATE;
              r_reached        <= 1'b1;
              state            <= S_FINISH;
            end else begin
              state <= S_PROF_X;
            end
          end
        end
        S_PROF_X: begin
          t1    <= 34'(kx) * 34'(ONE_Q16 - kx);
          state <= S_PROF_T;
        end
        S_PROF_T: begin
          // atan(a*x*(1-x)) as the angle of (2^32, a*x*(65536-x))
          cx    <= CW'(64'd1 << 32);
          cy    <= CW'(38'(prof_a) * 38'(t1));
          state <= S_NUM_GO;
        end
        S_NUM_GO: state <= S_NUM_WAIT;
        S_NUM_WAIT: begin
          if (cstat.done) begin
            num   <= c_angle;
            cx    <= CW'(4);
            cy    <= CW'(prof_a);
            state <= S_DEN_GO;
          end
        end
        S_DEN_GO: state <= S_DEN_WAIT;
        S_DEN_WAIT: begin
          if (cstat.done) begin
            den   <= c_angle;
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (den[15] || den == 16'd0) begin
            prof  <= ONE_Q16;
            state <= S_SPEED;
          end else begin
            dd    <= {3'd0, num_pos, 16'd0};
            dv    <= {1'b0, den};
            state <= S_PDIV_GO;
          end
        end
        S_PDIV_GO: state <= S_PDIV_WAIT;
        S_PDIV_WAIT: begin
          if (dstat.done) begin
            prof  <= (quot > DD_W'(ONE_Q16)) ? ONE_Q16 : quot[16:0];
            state <= S_SPEED;
          end
        end
        S_SPEED: begin
          sp    <= 17'(peak_prod >> 10) + SPEED_OFFSET;
          state <= S_STEER;
        end
        S_STEER: begin
          r_en <= 1'b1;
          if (phase == PH_ROTATE) begin
            r_lsp <= sp;
            r_rsp <= sp;
          end else if (err > 0) begin
            r_lsp <= sp_eff;
            r_rsp <= scaled;
          end else begin
            r_lsp <= scaled;
            r_rsp <= sp_eff;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            drive_enable     <= r_en;
            drive_mode       <= r_mode;
            left_speed       <= r_lsp;
            right_speed      <= r_rsp;
            phase_now        <= phase;
            waypoint_now     <= waypoint_index;
            waypoint_reached <= r_reached;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `WRMC_NEVER(a_units_exclusive, cstat.busy && dstat.busy, "cordic and divider busy together")
  `WRMC_ASSERT(a_accept_stalls, (in_valid && !in_stall) |=> in_stall, "item accepted twice")
  `WRMC_NEVER(a_phase_code, phase == 2'd3, "phase register holds unused code")

endmodule

@@ tb/sv/waypoint_rotate_move_controller_test.sv @@
// self-checking testbench for the waypoint controller: phase walk, cordic distance/bearing,
// progression and speed profile, checked item by item against an in-bench predictor
// depends on wrmc_pkg and the rtl of waypoint_rotate_move_controller
`timescale 1ns / 1ps
module waypoint_rotate_move_controller_test;
  import wrmc_pkg::*;

  // one control tick as driven on the input port
  typedef struct {
    logic signed [15:0] tx, ty;
    logic               back;
    logic signed [15:0] px, py;
    logic [15:0]        hd;
    logic               obf, obb, run;
  } tick_t;

  // one drive command as seen on the output port
  typedef struct packed {
    logic        en;
    logic [1:0]  mode;
    logic [16:0] lsp, rsp;
    logic [1:0]  ph;
    logic [7:0]  wp;
    logic        reached;
  } drive_t;

  // atan table in binary-angle units
  function automatic longint atan_step(input int i);
    return longint'(cordic_atan(5'(i)));
  endfunction

  function automatic int wrap16(input longint v);
    logic [15:0] b;
    b = v[15:0];
    return int'($signed(b));
  endfunction

  // floor shift for signed values
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  // vectoring cordic: bearing as signed binary angle, gain-laden magnitude in mag
  function automatic int vec_angle(input longint x0, input longint y0, output longint mag);
    longint x, y, xs, ys, z;
    x = x0; y = y0; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32768;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      xs = asr(x, i); ys = asr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    mag = x;
    return wrap16(z);
  endfunction

  // bell-shaped speed profile, Q16
  function automatic longint bell(input longint p, input longint a);
    longint k, x, t, num, den, m, r;
    k = (p * PROFILE_ENTRIES + 32768) >>> 16;
    x = (k * 65536) / PROFILE_ENTRIES;
    if (x > 65536) x = 65536;
    t = a * x * (65536 - x);
    num = vec_angle(longint'(1) << 32, t, m);
    den = vec_angle(4, a, m);
    if (num < 0) num = 0;
    if (den <= 0) return 65536;
    r = num * 65536 / den;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint clamp_q16(input longint p);
    if (p < 0) return 0;
    if (p > 65536) return 65536;
    return p;
  endfunction

  // predictor and store of expected drive commands
  class drive_scoreboard;
    int unsigned wp_count, rot_max, mov_max;
    logic [1:0]  ph;
    int unsigned wp_idx;
    int          turn0;       // captured turn, 0 = not captured
    longint      dist0;       // captured distance, 0 = not captured
    drive_t      pending[$];
    int          mismatches;
    int          checked;

    function void clear();
      wp_count = 0; rot_max = 0; mov_max = 0;
      ph = PH_STANDBY; wp_idx = 0; turn0 = 0; dist0 = 0;
      pending.delete(); mismatches = 0; checked = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [15:0] val);
      case (idx)
        CFG_WAYPOINT_COUNT: wp_count = val[7:0];
        CFG_ROTATE_MAX:     rot_max  = val[9:0];
        CFG_MOVE_MAX:       mov_max  = val[9:0];
        default: ;
      endcase
    endfunction

    // predict the command for one accepted tick
    function void note_tick(input tick_t t);
      drive_t d;
      longint dx, dy, mag, dist_mm, p, sp, scaled;
      int brg, err;
      dx = longint'(t.tx) - longint'(t.px);
      dy = longint'(t.ty) - longint'(t.py);
      brg = vec_angle(dx * 256, dy * 256, mag);
      if (mag < 0) mag = 0;
      dist_mm = (mag * longint'(KINV) + (longint'(1) << 37)) >>> 38;
      if (dist_mm > 131071) dist_mm = 131071;
      err = wrap16(longint'(brg) - longint'(t.hd));
      d = '{en: 0, mode: DM_NONE, lsp: 0, rsp: 0, ph: 0, wp: 0, reached: 0};
      case (ph)
        PH_STANDBY: begin
          if (wp_idx < wp_count && t.run) ph = PH_ROTATE;
        end
        PH_ROTATE: begin
          if (turn0 == 0) turn0 = err;
          if (turn0 == 0) p = 65536;
          else p = clamp_q16(65536 - (longint'(err) * 65536) / turn0);
          d.mode = (err > 0) ? DM_LEFT : DM_RIGHT;
          if (p * 1000 > 999 * 65536) begin
            ph = PH_MOVE; turn0 = 0;
          end else begin
            sp = ((rot_max * bell(p, 20)) >>> 10) + 48;
            d.lsp = sp[16:0]; d.rsp = sp[16:0]; d.en = 1;
          end
        end
        PH_MOVE: begin
          if (dist0 == 0) dist0 = dist_mm;
          if (dist0 == 0) p = 65536;
          else p = clamp_q16(65536 - (dist_mm * 65536) / dist0);
          d.mode = DM_FORWARD;
          if (dist0 < SHORT_MOVE_MM) sp = ((10 * bell(p, 10)) >>> 10) + 48;
          else sp = ((mov_max * bell(p, 20)) >>> 10) + 48;
          if ((t.obf && !t.back) || (t.obb && t.back)) begin
            sp = 0; dist0 = 0;
          end
          if (p * 100 > 95 * 65536) begin
            dist0 = 0;
            if (wp_idx < 255) wp_idx++;
            ph = (wp_idx >= wp_count) ? PH_STANDBY : PH_ROTATE;
            d.reached = 1;
          end else begin
            scaled = (sp * (32768 - longint'(err))) >>> 15;
            if (err > 0) begin
              d.lsp = sp[16:0]; d.rsp = scaled[16:0];
            end else begin
              d.lsp = scaled[16:0]; d.rsp = sp[16:0];
            end
            d.en = 1;
          end
        end
        default: ph = PH_STANDBY;
      endcase
      d.ph = ph; d.wp = wp_idx[7:0];
      pending.push_back(d);
    endfunction

    // compare one accepted command with the oldest prediction
    function void check_drive(input drive_t a);
      drive_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected drive command at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (a !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: exp en=%0d mode=%0d l=%0d r=%0d ph=%0d wp=%0d rch=%0d",
                   $realtime, e.en, e.mode, e.lsp, e.rsp, e.ph, e.wp, e.reached,
                   " got en=%0d mode=%0d l=%0d r=%0d ph=%0d wp=%0d rch=%0d",
                   a.en, a.mode, a.lsp, a.rsp, a.ph, a.wp, a.reached);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [15:0] target_x = 0, target_y = 0, pose_x = 0, pose_y = 0;
  logic               target_backward = 0;
  logic [15:0]        pose_heading = 0;
  logic               obstacle_front = 0, obstacle_back = 0, run_enable = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               drive_enable;
  logic [1:0]         drive_mode;
  logic [16:0]        left_speed, right_speed;
  logic [1:0]         phase_now;
  logic [7:0]         waypoint_now;
  logic               waypoint_reached;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 0;
  logic [15:0]        cfg_data = 0;

  waypoint_rotate_move_controller dut (.*);

  always #6 clk = ~clk;

  drive_scoreboard sb = new();
  int  n_sent, n_reached, n_moves;
  logic sink_random;         // receiver stalls at random

  // odometry state of a simulated robot, so the route actually progresses
  logic signed [15:0] rob_x, rob_y;
  logic [15:0]        rob_hd;

  // result side: random stall per item, sample at rising edge
  initial begin
    drive_t a;
    int w;
    sink_random = 1;
    @(negedge clk);
    forever begin
      w = (sink_random && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      a = '{drive_enable, drive_mode, left_speed, right_speed, phase_now,
            waypoint_now, waypoint_reached};
      sb.check_drive(a);
      if (a.reached) n_reached++;
      if (a.ph == PH_MOVE) n_moves++;
      @(negedge clk);
    end
  end

  // register write, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // send one tick after a random gap, wait for acceptance
  task automatic send_tick(input tick_t t, input bit gap);
    int w;
    w = (gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 11) : 0;
    repeat (w + 1) @(negedge clk);
    in_valid <= 1;
    target_x <= t.tx; target_y <= t.ty; target_backward <= t.back;
    pose_x <= t.px; pose_y <= t.py; pose_heading <= t.hd;
    obstacle_front <= t.obf; obstacle_back <= t.obb; run_enable <= t.run;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
    n_sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  // wait until every predicted command has come, then let the block settle
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.tx = 16'($urandom); t.ty = 16'($urandom);
    t.px = 16'($urandom); t.py = 16'($urandom);
    t.hd = 16'($urandom); t.back = $urandom_range(0, 1);
    t.obf = ($urandom_range(0, 3) == 0); t.obb = ($urandom_range(0, 3) == 0);
    t.run = ($urandom_range(0, 4) != 0);
    return t;
  endfunction

  // tick from the simulated robot chasing a target; the pose steps toward it
  // so rotate and move phases run to completion
  function automatic tick_t robot_tick(input logic signed [15:0] gx,
                                       input logic signed [15:0] gy, input logic bk);
    tick_t t;
    t = '{gx, gy, bk, rob_x, rob_y, rob_hd, 1'b0, 1'b0, 1'b1};
    if ($urandom_range(0, 19) == 0) t.obf = 1;
    if ($urandom_range(0, 19) == 0) t.obb = 1;
    return t;
  endfunction

  task automatic advance_robot(input logic signed [15:0] gx, input logic signed [15:0] gy);
    longint m;
    int brg;
    brg = vec_angle((longint'(gx) - rob_x) * 256, (longint'(gy) - rob_y) * 256, m);
    if (sb.ph == PH_ROTATE)
      rob_hd = rob_hd + 16'((brg - int'($signed(rob_hd))) / 3 + $urandom_range(0, 40) - 20);
    else if (sb.ph == PH_MOVE) begin
      rob_x = rob_x + 16'((int'(gx) - int'(rob_x)) / 4);
      rob_y = rob_y + 16'((int'(gy) - int'(rob_y)) / 4);
    end
  endtask

  initial begin
    logic signed [15:0] gx, gy;
    logic bk;
    sb.clear();
    rob_x = 0; rob_y = 0; rob_hd = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, each phase, coincident points, obstacles
    write_reg(CFG_WAYPOINT_COUNT, 16'd3);
    write_reg(CFG_ROTATE_MAX, 16'd1023);
    write_reg(CFG_MOVE_MAX, 16'd1023);
    send_tick('{16'sh7FFF, 16'sh7FFF, 0, -16'sh8000, -16'sh8000, 16'hFFFF, 0, 0, 0}, 0);
    send_tick('{0, 0, 0, 0, 0, 0, 0, 0, 1}, 0);                 // leave standby
    send_tick('{0, 0, 0, 0, 0, 0, 0, 0, 1}, 0);                 // coincident points during rotation
    send_tick('{0, 0, 0, 0, 0, 0, 1, 1, 1}, 0);                 // coincident points with both obstacles set
    send_tick('{-16'sh8000, 16'sh7FFF, 1, 16'sh7FFF, -16'sh8000, 16'h8000, 1, 1, 1}, 0);
    send_tick('{-16'sh8000, 16'sh7FFF, 1, 16'sh7FFF, -16'sh8000, 16'h4000, 0, 1, 1}, 0);
    send_tick('{100, 0, 0, 0, 0, 16'h0000, 1, 0, 1}, 0);
    send_tick('{100, 0, 0, 0, 0, 16'h0000, 0, 1, 0}, 0);
    send_tick('{30, 5, 0, 0, 0, 16'h0100, 0, 0, 1}, 0);          // short remaining distance within a longer move
    send_tick('{30, 5, 1, 29, 5, 16'hFF00, 0, 0, 1}, 0);
    send_tick('{0, -500, 0, 0, 0, 16'hC000, 0, 0, 1}, 0);
    send_tick('{0, -500, 0, 0, -490, 16'hC000, 0, 0, 1}, 0);
    for (int i = 0; i < 8; i++) send_tick(rand_tick(), 1);
    drain();

    // random phases with several settings, extremes among them
    for (int ph_i = 0; ph_i < 8 && !$isunknown(ph_i); ph_i++) begin
      case (ph_i)
        0: begin write_reg(CFG_WAYPOINT_COUNT, 16'd255); write_reg(CFG_ROTATE_MAX, 16'd0);
                 write_reg(CFG_MOVE_MAX, 16'd0); end
        1: begin write_reg(CFG_WAYPOINT_COUNT, 16'd0); write_reg(CFG_ROTATE_MAX, 16'd1023);
                 write_reg(CFG_MOVE_MAX, 16'd1023); end
        default: begin
          write_reg(CFG_WAYPOINT_COUNT, 16'($urandom));
          write_reg(CFG_ROTATE_MAX, 16'($urandom));
          write_reg(CFG_MOVE_MAX, 16'($urandom));
        end
      endcase
      sink_random = (ph_i != 3);
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 4) == 0) send_tick(rand_tick(), ph_i != 4);
        else begin
          // well-formed route leg, random target, robot follows
          gx = 16'($urandom_range(0, 4000)) - 16'sd2000;
          gy = 16'($urandom_range(0, 4000)) - 16'sd2000;
          if ($urandom_range(0, 3) == 0) begin
            gx = rob_x + 16'($urandom_range(0, 60)) - 16'sd30;
            gy = rob_y + 16'($urandom_range(0, 60)) - 16'sd30;
          end
          bk = $urandom_range(0, 1);
          for (int s = 0; s < 24 && n < 240; s++, n++) begin
            send_tick(robot_tick(gx, gy, bk), ph_i != 4);
            advance_robot(gx, gy);
          end
        end
        if (n == 120) drain();     // sender holds off until all commands are back
      end
      drain();
    end

    $display("sent %0d ticks, checked %0d commands", n_sent, sb.checked);
    $display("%0d commands in move phase, %0d waypoints reached", n_moves, n_reached);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d left over", sb.mismatches, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 1500000);
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end
endmodule
